### design/rcdid_pkg.sv
// Package for the RGB565 cached delta image decoder.
// Holds the shared pixel and emit descriptor types, opcode codes and sizes.
// No dependencies.
package rcdid_pkg;

   localparam int unsigned DEF_MAX_PIXELS = 16777216;
   localparam int CFG_W = 25;
   localparam int RUN_W = 6;
   localparam int IDX_W = 6;
   localparam int CACHE_DEPTH = 64;

   localparam logic [7:0] OP_RGB = 8'hFE;
   localparam logic [7:0] OP_RGBA = 8'hFF;

   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF = 2'b01;
   localparam logic [1:0] TAG_LUMA = 2'b10;
   localparam logic [1:0] TAG_RUN = 2'b11;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_RGB,
      PEND_RGBA,
      PEND_LUMA
   } pend_type;

   typedef struct packed {
      logic [4:0] red;
      logic [5:0] green;
      logic [4:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic [RUN_W-1:0] count;
      logic image_end;
   } emit_type;

   localparam pixel_type RESET_PIXEL = '{red: 5'd0, green: 6'd0, blue: 5'd0, alpha: 8'hFF};

endpackage

### design/rgb565_cached_delta_image_decoder.sv
// Top level of the RGB565 cached delta image decoder.
// Holds the color cache memory and the decode stage; uses rcdid_emit and rcdid_pkg.
//
// Usage: compressed payload bytes enter on the req_ channel, one per transaction,
// with req_first_byte marking the start of an image and req_last_byte the end.
// RGBA pixels leave on the rsp_ channel, one per transaction. csr_pixel_total
// sets the image size; the user must write it with csr_write_enable only while
// the block idles; the block does not enforce this. An accepted byte and its cache
// read are registered in the decode stage, and its first pixel is registered in
// the emitter and offered on rsp_valid. One byte is taken per cycle unless the
// emitter is busy; a run byte occupies the emitter for n+1 pixels, one pixel per
// cycle while rsp_ready is high, and the next bytes wait in the decode stage
// meanwhile. Bytes with no pixel pass the decode stage even while the output stalls.
// The cache memory, with one read port, one write port and a forwarding register,
// sustains one read and one write per cycle.
// Reset sets the colour to opaque black, clears the pending opcode, pixel count and
// all cache valid bits, and sets the pixel total to one; no clearing sweep is
// needed. When rsp_ready is low, the pixel on the output holds, then the decode
// stage fills and req_ready drops.
module rgb565_cached_delta_image_decoder #(
   parameter int unsigned MAX_PIXELS = rcdid_pkg::DEF_MAX_PIXELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_payload_byte,
   input  logic                        req_first_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_red,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_blue,
   output logic [7:0]                  rsp_alpha,
   output logic                        rsp_run_end,
   output logic                        rsp_image_end,
   input  logic                        csr_write_enable,
   input  logic [rcdid_pkg::CFG_W-1:0] csr_pixel_total
);

   localparam int IDX_W = rcdid_pkg::IDX_W;
   localparam int RUN_W = rcdid_pkg::RUN_W;
   localparam int CNT_W = ($clog2(MAX_PIXELS + 1) > RUN_W) ? $clog2(MAX_PIXELS + 1) : RUN_W;

   function automatic logic [IDX_W-1:0] cache_hash(input rcdid_pkg::pixel_type p);
      logic [7:0] sum;
      sum = 8'(8'(p.red) * 8'd7) + 8'(8'(p.green) * 8'd5) + 8'(8'(p.blue) * 8'd3);
      return sum[IDX_W-1:0];
   endfunction

   // Configuration.
   logic [rcdid_pkg::CFG_W-1:0] total_ff;
   logic [CNT_W-1:0]            limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= rcdid_pkg::CFG_W'(1);
      end else if (csr_write_enable) begin
         total_ff <= csr_pixel_total;
      end
   end

   assign limit = (total_ff > rcdid_pkg::CFG_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                            : CNT_W'(total_ff);

   // Decode stage register.
   logic       ex_valid_ff;
   logic [7:0] ex_byte_ff;
   logic       ex_first_ff;
   logic       ex_last_ff;
   logic       ex_fire;
   logic       req_accept;

   assign req_ready = !ex_valid_ff || ex_fire;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (req_ready) begin
         ex_valid_ff <= req_valid;
      end
      if (req_accept) begin
         ex_byte_ff <= req_payload_byte;
         ex_first_ff <= req_first_byte;
         ex_last_ff <= req_last_byte;
      end
   end

   // Color cache memory with valid bits and a forwarding register.
   rcdid_pkg::pixel_type         cache_mem [rcdid_pkg::CACHE_DEPTH];
   rcdid_pkg::pixel_type         mem_q_ff;
   rcdid_pkg::pixel_type         fwd_data_ff;
   logic                         fwd_hit_ff;
   logic [rcdid_pkg::CACHE_DEPTH-1:0] cvalid_ff, cvalid_in;
   logic                         cache_we;
   logic [IDX_W-1:0]             wr_addr;
   rcdid_pkg::pixel_type         wr_data;
   rcdid_pkg::pixel_type         cache_entry;

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[wr_addr] <= wr_data;
      end
      if (req_accept) begin
         mem_q_ff <= cache_mem[req_payload_byte[IDX_W-1:0]];
         fwd_data_ff <= wr_data;
         fwd_hit_ff <= cache_we && (wr_addr == req_payload_byte[IDX_W-1:0]);
      end
   end

   always_comb begin
      cvalid_in = cvalid_ff;
      if (ex_fire && ex_first_ff) begin
         cvalid_in = '0;
      end
      if (cache_we) begin
         cvalid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
      end else begin
         cvalid_ff <= cvalid_in;
      end
   end

   always_comb begin
      if (ex_first_ff || !cvalid_ff[ex_byte_ff[IDX_W-1:0]]) begin
         cache_entry = '0;
      end else if (fwd_hit_ff) begin
         cache_entry = fwd_data_ff;
      end else begin
         cache_entry = mem_q_ff;
      end
   end

   // Decoder state.
   rcdid_pkg::pixel_type cur_ff, cur_in;
   rcdid_pkg::pend_type  pend_ff, pend_in;
   logic [1:0]           pcnt_ff, pcnt_in;
   logic [7:0]           lo_ff, lo_in;
   logic [7:0]           hi_ff, hi_in;
   logic [5:0]           op_ff, op_in;
   logic [CNT_W-1:0]     done_ff, done_in;

   rcdid_pkg::pixel_type eff_pix;
   rcdid_pkg::pend_type  eff_kind;
   logic [1:0]           eff_cnt;
   logic [CNT_W-1:0]     eff_done;
   logic                 active;
   logic [1:0]           tag;
   logic [RUN_W-1:0]     count;
   logic [CNT_W-1:0]     remaining;
   logic                 reach_end;
   logic [RUN_W-1:0]     emitted;
   logic                 need_emit;
   logic                 emit_ready;
   rcdid_pkg::emit_type  desc;
   logic [5:0]           vg;

   assign eff_pix = ex_first_ff ? rcdid_pkg::RESET_PIXEL : cur_ff;
   assign eff_kind = ex_first_ff ? rcdid_pkg::PEND_NONE : pend_ff;
   assign eff_cnt = ex_first_ff ? 2'd0 : pcnt_ff;
   assign eff_done = ex_first_ff ? '0 : done_ff;
   assign active = eff_done < limit;
   assign tag = ex_byte_ff[7:6];
   assign vg = op_ff - 6'd32;

   // Pending opcode next state.
   always_comb begin
      pend_in = eff_kind;
      pcnt_in = eff_cnt;
      unique case (eff_kind)
         rcdid_pkg::PEND_RGB: begin
            if (eff_cnt == 2'd0) begin
               pcnt_in = 2'd1;
            end else begin
               pend_in = rcdid_pkg::PEND_NONE;
               pcnt_in = 2'd0;
            end
         end
         rcdid_pkg::PEND_RGBA: begin
            if (eff_cnt == 2'd0) begin
               pcnt_in = 2'd1;
            end else if (eff_cnt == 2'd1) begin
               pcnt_in = 2'd2;
            end else begin
               pend_in = rcdid_pkg::PEND_NONE;
               pcnt_in = 2'd0;
            end
         end
         rcdid_pkg::PEND_LUMA: begin
            pend_in = rcdid_pkg::PEND_NONE;
            pcnt_in = 2'd0;
         end
         rcdid_pkg::PEND_NONE: begin
            pcnt_in = 2'd0;
            if (ex_byte_ff == rcdid_pkg::OP_RGB) begin
               pend_in = rcdid_pkg::PEND_RGB;
            end else if (ex_byte_ff == rcdid_pkg::OP_RGBA) begin
               pend_in = rcdid_pkg::PEND_RGBA;
            end else if (tag == rcdid_pkg::TAG_LUMA) begin
               pend_in = rcdid_pkg::PEND_LUMA;
            end
         end
      endcase
      if (ex_last_ff) begin
         pend_in = rcdid_pkg::PEND_NONE;
         pcnt_in = 2'd0;
      end
      if (!active) begin
         pend_in = eff_kind;
         pcnt_in = eff_cnt;
      end
   end

   // Color datapath and pixel count.
   always_comb begin
      cur_in = eff_pix;
      count = '0;
      lo_in = lo_ff;
      hi_in = hi_ff;
      op_in = op_ff;
      case (eff_kind)
         rcdid_pkg::PEND_RGB, rcdid_pkg::PEND_RGBA: begin
            if (eff_cnt == 2'd0) begin
               lo_in = ex_byte_ff;
            end else if (eff_cnt == 2'd1) begin
               hi_in = ex_byte_ff;
               if (eff_kind == rcdid_pkg::PEND_RGB) begin
                  cur_in.blue = lo_ff[4:0];
                  cur_in.green = {ex_byte_ff[2:0], lo_ff[7:5]};
                  cur_in.red = ex_byte_ff[7:3];
                  count = RUN_W'(1);
               end
            end else begin
               cur_in.blue = lo_ff[4:0];
               cur_in.green = {hi_ff[2:0], lo_ff[7:5]};
               cur_in.red = hi_ff[7:3];
               cur_in.alpha = ex_byte_ff;
               count = RUN_W'(1);
            end
         end
         rcdid_pkg::PEND_LUMA: begin
            cur_in.green = eff_pix.green + vg;
            cur_in.red = eff_pix.red + vg[4:0] - 5'd8 + {1'b0, ex_byte_ff[3:0]};
            cur_in.blue = eff_pix.blue + vg[4:0] - 5'd8 + {1'b0, ex_byte_ff[7:4]};
            count = RUN_W'(1);
         end
         default: begin
            if (ex_byte_ff != rcdid_pkg::OP_RGB && ex_byte_ff != rcdid_pkg::OP_RGBA) begin
               case (tag)
                  rcdid_pkg::TAG_INDEX: begin
                     cur_in = cache_entry;
                     count = RUN_W'(1);
                  end
                  rcdid_pkg::TAG_DIFF: begin
                     cur_in.red = eff_pix.red + {3'b000, ex_byte_ff[1:0]} - 5'd2;
                     cur_in.green = eff_pix.green + {4'b0000, ex_byte_ff[3:2]} - 6'd2;
                     cur_in.blue = eff_pix.blue + {3'b000, ex_byte_ff[5:4]} - 5'd2;
                     count = RUN_W'(1);
                  end
                  rcdid_pkg::TAG_LUMA: begin
                     op_in = ex_byte_ff[5:0];
                  end
                  default: begin
                     count = ex_byte_ff[5:0] + RUN_W'(1);
                  end
               endcase
            end
         end
      endcase
      if (!active) begin
         cur_in = eff_pix;
         count = '0;
      end
   end

   assign remaining = limit - eff_done;
   assign reach_end = CNT_W'(count) >= remaining;
   assign emitted = reach_end ? remaining[RUN_W-1:0] : count;
   assign need_emit = (count != '0);
   assign done_in = eff_done + CNT_W'(emitted);

   assign ex_fire = ex_valid_ff && (!need_emit || emit_ready);
   assign cache_we = ex_fire && need_emit;
   assign wr_addr = cache_hash(cur_in);
   assign wr_data = cur_in;

   assign desc.pix = cur_in;
   assign desc.count = emitted;
   assign desc.image_end = reach_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= rcdid_pkg::RESET_PIXEL;
         pend_ff <= rcdid_pkg::PEND_NONE;
         pcnt_ff <= 2'd0;
         done_ff <= '0;
      end else if (ex_fire) begin
         cur_ff <= cur_in;
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         done_ff <= done_in;
      end
      if (ex_fire) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         op_ff <= op_in;
      end
   end

   rcdid_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (ex_valid_ff && need_emit),
      .load_ready    (emit_ready),
      .load_desc     (desc),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_alpha     (rsp_alpha),
      .rsp_run_end   (rsp_run_end),
      .rsp_image_end (rsp_image_end)
   );

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ex_valid_ff)
      else $error("accepted transaction missing from the decode stage");

   a_clear_valid: assert property (@(posedge clock) disable iff (reset)
      (ex_fire && ex_first_ff) |=> ($countones(cvalid_ff) <= 1))
      else $error("cache valid bits survived an image start");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && !ex_fire) |=> $stable(done_ff))
      else $error("pixel count moved while the decode stage stalled");

endmodule

### design/rcdid_emit.sv
// Pixel emitter and output register of the image decoder.
// Replays one color for a run of pixels, one per response transaction.
// Depends on rcdid_pkg.
module rcdid_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  rcdid_pkg::emit_type load_desc,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_alpha,
   output logic                rsp_run_end,
   output logic                rsp_image_end
);

   logic                        valid_ff, valid_in;
   logic [rcdid_pkg::RUN_W-1:0] cnt_ff, cnt_in;
   logic                        end_ff, end_in;
   rcdid_pkg::pixel_type        pix_ff, pix_in;
   logic                        last_pix;

   assign last_pix = (cnt_ff == rcdid_pkg::RUN_W'(1));
   assign load_ready = !valid_ff || (rsp_ready && last_pix);

   always_comb begin
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      end_in = end_ff;
      pix_in = pix_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         cnt_in = load_desc.count;
         end_in = load_desc.image_end;
         pix_in = load_desc.pix;
      end else if (valid_ff && rsp_ready) begin
         cnt_in = cnt_ff - rcdid_pkg::RUN_W'(1);
         if (last_pix) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      end_ff <= end_in;
      pix_ff <= pix_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_red = {pix_ff.red, 3'b000};
   assign rsp_green = {pix_ff.green, 2'b00};
   assign rsp_blue = {pix_ff.blue, 3'b000};
   assign rsp_alpha = pix_ff.alpha;
   assign rsp_run_end = last_pix;
   assign rsp_image_end = end_ff && last_pix;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cnt_ff != '0))
      else $error("emitter holds a run of zero pixels");

   a_image_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_run_end)
      else $error("image end flagged before the last pixel of a run");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load_valid && load_ready) |=> rsp_valid)
      else $error("loaded run did not reach the output");

endmodule

### tb/sv/rgb565_cached_delta_image_decoder_tb.sv
// Self-checking testbench for rgb565_cached_delta_image_decoder: directed opcode table,
// then random opcode streams under several image sizes, with sender bursts and sink stalls.
// Depends on rcdid_pkg and the decoder RTL; holds its own decoder predictor.
module rgb565_cached_delta_image_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 12;
   localparam int CYCLE_LIMIT = 900000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 22;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       run_end;
      logic       image_end;
   } rgba_pixel_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} check_kind_type;
   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_type;
   typedef enum logic [2:0] {
      OPK_NOISE, OPK_RGB, OPK_RGBA, OPK_INDEX, OPK_DIFF, OPK_LUMA, OPK_RUN
   } op_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [24:0]    value;
      logic           is_first;
      logic           is_last;
      check_kind_type check;
      rgba_pixel_type pixel;
   } script_row_type;

   localparam rgba_pixel_type NO_PIXEL = '0;

   localparam script_row_type SCRIPT [30] = '{
      '{ROW_BYTE, 25'h0C5, 1'b1, 1'b0, CHK_PIXEL, '{8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1}},
      '{ROW_BYTE, 25'h055, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_CSR, 25'h0000000, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h000, 1'b1, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_CSR, 25'h1FFFFFF, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h000, 1'b1, 1'b0, CHK_PIXEL, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h07F, 1'b0, 1'b0, CHK_PIXEL, '{8'd8, 8'd4, 8'd8, 8'd0, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h040, 1'b0, 1'b0, CHK_PIXEL, '{8'd248, 8'd252, 8'd248, 8'd0, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h0FE, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h0FF, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h0FF, 1'b0, 1'b0, CHK_PIXEL, '{8'd248, 8'd252, 8'd248, 8'd0, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h0FF, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h000, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h000, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h080, 1'b0, 1'b0, CHK_PIXEL, '{8'd0, 8'd0, 8'd0, 8'd128, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h080, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h000, 1'b0, 1'b0, CHK_PIXEL, '{8'd192, 8'd128, 8'd192, 8'd128, 1'b1, 1'b0}},
      '{ROW_BYTE, 25'h0BF, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h0FF, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h0FD, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h03F, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h0FE, 1'b0, 1'b1, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h012, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h0FF, 1'b0, 1'b0, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h012, 1'b0, 1'b1, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h09A, 1'b0, 1'b1, CHK_NONE, NO_PIXEL},
      '{ROW_BYTE, 25'h0C1, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_CSR, 25'h0000005, 1'b0, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h0C9, 1'b1, 1'b0, CHK_MODEL, NO_PIXEL},
      '{ROW_BYTE, 25'h044, 1'b0, 1'b0, CHK_NONE, NO_PIXEL}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [7:0]                  req_payload_byte = '0;
   logic                        req_first_byte = 1'b0;
   logic                        req_last_byte = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [7:0]                  rsp_red;
   logic [7:0]                  rsp_green;
   logic [7:0]                  rsp_blue;
   logic [7:0]                  rsp_alpha;
   logic                        rsp_run_end;
   logic                        rsp_image_end;
   logic                        csr_write_enable = 1'b0;
   logic [rcdid_pkg::CFG_W-1:0] csr_pixel_total = '0;

   rgba_pixel_type              pixels_due [$];
   int                          mismatch_count = 0;
   int                          burst_left = 0;

   rcdid_pkg::pixel_type        colour_now;
   rcdid_pkg::pixel_type        palette [rcdid_pkg::CACHE_DEPTH];
   rcdid_pkg::pend_type         open_kind;
   logic [1:0]                  open_count;
   logic [7:0]                  lo_byte;
   logic [7:0]                  hi_byte;
   logic [7:0]                  luma_op;
   int unsigned                 pix_emitted;
   logic [rcdid_pkg::CFG_W-1:0] image_size;

   sink_mode_type               sink_mode = SINK_OPEN;
   int unsigned                 sink_left = 0;

   rgb565_cached_delta_image_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_run_end      (rsp_run_end),
      .rsp_image_end    (rsp_image_end),
      .csr_write_enable (csr_write_enable),
      .csr_pixel_total  (csr_pixel_total)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void clear_image();
      colour_now = rcdid_pkg::RESET_PIXEL;
      foreach (palette[i]) palette[i] = '0;
      open_kind = rcdid_pkg::PEND_NONE;
      open_count = '0;
      lo_byte = '0;
      hi_byte = '0;
      luma_op = '0;
      pix_emitted = 0;
   endfunction

   function automatic int unsigned image_pixel_limit();
      return (image_size > rcdid_pkg::DEF_MAX_PIXELS) ? rcdid_pkg::DEF_MAX_PIXELS
                                                      : 32'(image_size);
   endfunction

   function automatic void load_565();
      colour_now.blue = lo_byte[4:0];
      colour_now.green = {hi_byte[2:0], lo_byte[7:5]};
      colour_now.red = hi_byte[7:3];
   endfunction

   function automatic void emit_pixels(input int unsigned n);
      int unsigned lim;
      rgba_pixel_type px;
      lim = image_pixel_limit();
      while (n > 0 && pix_emitted < lim) begin
         palette[6'(7 * colour_now.red + 5 * colour_now.green + 3 * colour_now.blue)] = colour_now;
         pix_emitted++;
         n--;
         px.red = {colour_now.red, 3'b000};
         px.green = {colour_now.green, 2'b00};
         px.blue = {colour_now.blue, 3'b000};
         px.alpha = colour_now.alpha;
         px.image_end = (pix_emitted == lim);
         px.run_end = (n == 0) || px.image_end;
         pixels_due.push_back(px);
      end
   endfunction

   // Returns 0 when the byte is ignored because the image is already complete.
   function automatic bit decode_byte(input logic [7:0] b, input logic is_first,
                                      input logic is_last);
      int unsigned count;
      int vg;
      count = 0;
      if (is_first) clear_image();
      if (pix_emitted >= image_pixel_limit()) return 1'b0;
      if (open_kind == rcdid_pkg::PEND_RGB || open_kind == rcdid_pkg::PEND_RGBA) begin
         if (open_count == 2'd0) begin
            lo_byte = b;
            open_count = 2'd1;
         end else if (open_count == 2'd1) begin
            hi_byte = b;
            if (open_kind == rcdid_pkg::PEND_RGB) begin
               load_565();
               open_kind = rcdid_pkg::PEND_NONE;
               open_count = 2'd0;
               count = 1;
            end else begin
               open_count = 2'd2;
            end
         end else begin
            load_565();
            colour_now.alpha = b;
            open_kind = rcdid_pkg::PEND_NONE;
            open_count = 2'd0;
            count = 1;
         end
      end else if (open_kind == rcdid_pkg::PEND_LUMA) begin
         vg = int'(luma_op[5:0]) - 32;
         colour_now.blue = 5'(int'(colour_now.blue) + vg - 8 + int'(b[7:4]));
         colour_now.green = 6'(int'(colour_now.green) + vg);
         colour_now.red = 5'(int'(colour_now.red) + vg - 8 + int'(b[3:0]));
         open_kind = rcdid_pkg::PEND_NONE;
         open_count = 2'd0;
         count = 1;
      end else if (b == rcdid_pkg::OP_RGB) begin
         open_kind = rcdid_pkg::PEND_RGB;
         open_count = 2'd0;
      end else if (b == rcdid_pkg::OP_RGBA) begin
         open_kind = rcdid_pkg::PEND_RGBA;
         open_count = 2'd0;
      end else begin
         case (b[7:6])
            rcdid_pkg::TAG_INDEX: begin
               colour_now = palette[b[5:0]];
               count = 1;
            end
            rcdid_pkg::TAG_DIFF: begin
               colour_now.blue = 5'(int'(colour_now.blue) + int'(b[5:4]) - 2);
               colour_now.green = 6'(int'(colour_now.green) + int'(b[3:2]) - 2);
               colour_now.red = 5'(int'(colour_now.red) + int'(b[1:0]) - 2);
               count = 1;
            end
            rcdid_pkg::TAG_LUMA: begin
               luma_op = b;
               open_kind = rcdid_pkg::PEND_LUMA;
               open_count = 2'd0;
            end
            rcdid_pkg::TAG_RUN: begin
               count = int'(b[5:0]) + 1;
            end
         endcase
      end
      if (is_last && open_kind != rcdid_pkg::PEND_NONE) begin
         open_kind = rcdid_pkg::PEND_NONE;
         open_count = 2'd0;
      end
      if (count > 0) emit_pixels(count);
      return 1'b1;
   endfunction

   function automatic string pixel_text(input rgba_pixel_type p);
      return $sformatf("rgba=%0d,%0d,%0d,%0d run_end=%0b image_end=%0b",
                       p.red, p.green, p.blue, p.alpha, p.run_end, p.image_end);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                            input check_kind_type check, input rgba_pixel_type typed,
                            output bit used);
      int mark;
      req_valid <= 1'b1;
      req_payload_byte <= b;
      req_first_byte <= is_first;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mark = pixels_due.size();
      used = decode_byte(b, is_first, is_last);
      if (check != CHK_MODEL) begin
         while (pixels_due.size() > mark) void'(pixels_due.pop_back());
         if (check == CHK_PIXEL) pixels_due.push_back(typed);
      end
      @(negedge clock);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_pixels();
      while (pixels_due.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_image_size(input logic [rcdid_pkg::CFG_W-1:0] total);
      req_valid <= 1'b0;
      wait_for_pixels();
      csr_write_enable <= 1'b1;
      csr_pixel_total <= total;
      image_size = total;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed opcodes with random content, plus noise bytes, stray
   // image starts and last-byte marks that cut opcodes short.
   task automatic random_stream(input int target);
      logic [7:0] seq [$];
      logic [5:0] run_len;
      int         useful;
      bit         fresh;
      bit         used;
      logic       is_first;
      logic       is_last;
      useful = 0;
      fresh = 1'b1;
      while (useful < target) begin
         seq.delete();
         case (op_kind_type'($urandom_range(0, 6)))
            OPK_RGB: begin
               seq.push_back(rcdid_pkg::OP_RGB);
               seq.push_back(8'($urandom));
               seq.push_back(8'($urandom));
            end
            OPK_RGBA: begin
               seq.push_back(rcdid_pkg::OP_RGBA);
               seq.push_back(8'($urandom));
               seq.push_back(8'($urandom));
               seq.push_back(8'($urandom));
            end
            OPK_INDEX: seq.push_back({rcdid_pkg::TAG_INDEX, 6'($urandom)});
            OPK_DIFF: seq.push_back({rcdid_pkg::TAG_DIFF, 6'($urandom)});
            OPK_LUMA: begin
               seq.push_back({rcdid_pkg::TAG_LUMA, 6'($urandom)});
               seq.push_back(8'($urandom));
            end
            OPK_RUN: begin
               run_len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 61))
                                                     : 6'($urandom_range(0, 5));
               seq.push_back({rcdid_pkg::TAG_RUN, run_len});
            end
            default: seq.push_back(8'($urandom));
         endcase
         foreach (seq[i]) begin
            is_first = fresh || ($urandom_range(0, 59) == 0);
            is_last = (i == seq.size() - 1) ? ($urandom_range(0, 7) == 0)
                                            : ($urandom_range(0, 24) == 0);
            fresh = 1'b0;
            send_byte(seq[i], is_first, is_last, CHK_MODEL, NO_PIXEL, used);
            pace_sender();
            if (used) useful++;
         end
         if (pix_emitted >= image_pixel_limit() || $urandom_range(0, 29) == 0) fresh = 1'b1;
      end
   endtask

   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = (sink_mode == SINK_HOLD) ? $urandom_range(1, 24) : $urandom_range(16, 96);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : pixel_check
      rgba_pixel_type seen;
      rgba_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_run_end, rsp_image_end};
         if (pixels_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected pixel, expected none, got %s", $time, pixel_text(seen));
         end else begin
            want = pixels_due.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               $display("%0t: pixel differs, expected %s, got %s", $time,
                        pixel_text(want), pixel_text(seen));
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [rcdid_pkg::CFG_W-1:0] total;
      bit used;
      image_size = 25'd1;
      clear_image();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            set_image_size(SCRIPT[i].value);
         end else begin
            send_byte(SCRIPT[i].value[7:0], SCRIPT[i].is_first, SCRIPT[i].is_last,
                      SCRIPT[i].check, SCRIPT[i].pixel, used);
            pace_sender();
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: total = 25'(rcdid_pkg::DEF_MAX_PIXELS);
            1: total = 25'($urandom_range(2, 40));
            2: total = 25'd1;
            3: total = 25'($urandom_range(41, 400));
            4: total = {1'b1, 24'($urandom)};
            default: total = 25'($urandom_range(1, 40));
         endcase
         set_image_size(total);
         random_stream(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      wait_for_pixels();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
